// ===== rtl/core/tlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged LRU lookup cache package
// Shared types and codes for the cache core and its slot cells.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_ADD    = 1'b1;

    typedef enum logic [2:0] {
        STATUS_MISS    = 3'd0,
        STATUS_HIT     = 3'd1,
        STATUS_UPDATED = 3'd2,
        STATUS_FILLED  = 3'd3,
        STATUS_EVICTED = 3'd4,
        STATUS_IGNORED = 3'd5
    } status_t;

    // Search token that travels down the row of cells.
    typedef struct packed {
        logic        active;
        logic        hit;
        logic        free;
        logic [31:0] hit_value;
        logic [31:0] min_stamp;
    } scan_t;

    // Write command broadcast from the core to every cell.
    typedef struct packed {
        logic        en;
        logic        set_key;
        logic        set_value;
        logic [31:0] owner;
        logic [31:0] number;
        logic [31:0] value;
        logic [31:0] stamp;
    } wr_cmd_t;

endpackage

// ===== rtl/core/tlc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged LRU lookup cache slot cell
// Holds one slot, folds it into the passing search token and takes writes.
// ----------------------------------------------------------------------------
module tlc_cell #(
    parameter int IDX_W = 7,
    parameter int INDEX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [31:0]       key_owner,
    input  logic [31:0]       key_number,
    input  tlc_pkg::scan_t    scan_in,
    input  logic [IDX_W-1:0]  hit_idx_in,
    input  logic [IDX_W-1:0]  free_idx_in,
    input  logic [IDX_W-1:0]  min_idx_in,
    output tlc_pkg::scan_t    scan_out,
    output logic [IDX_W-1:0]  hit_idx_out,
    output logic [IDX_W-1:0]  free_idx_out,
    output logic [IDX_W-1:0]  min_idx_out,
    input  tlc_pkg::wr_cmd_t  wr,
    input  logic [IDX_W-1:0]  wr_idx
);
    import tlc_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic              valid_reg;
    logic [31:0]       owner_reg;
    logic [31:0]       number_reg;
    logic [31:0]       value_reg;
    logic [31:0]       stamp_reg;
    scan_t             scan_reg;
    scan_t             scan_next;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [IDX_W-1:0]  hit_idx_next;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [IDX_W-1:0]  free_idx_next;
    logic [IDX_W-1:0]  min_idx_reg;
    logic [IDX_W-1:0]  min_idx_next;
    logic              match;
    logic              wr_sel;

    assign match  = valid_reg && (owner_reg == key_owner) && (number_reg == key_number);
    assign wr_sel = wr.en && (wr_idx == MY_IDX);

    always_comb begin
        scan_next     = scan_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        min_idx_next  = min_idx_in;
        if (!scan_in.hit && match) begin
            scan_next.hit       = 1'b1;
            scan_next.hit_value = value_reg;
            hit_idx_next        = MY_IDX;
        end
        if (!scan_in.free && !valid_reg) begin
            scan_next.free = 1'b1;
            free_idx_next  = MY_IDX;
        end
        if (valid_reg && (stamp_reg < scan_in.min_stamp)) begin
            scan_next.min_stamp = stamp_reg;
            min_idx_next        = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            scan_reg.active <= 1'b0;
        end else begin
            if (wr_sel) begin
                valid_reg <= 1'b1;
            end
            scan_reg.active <= scan_next.active;
        end
        scan_reg.hit       <= scan_next.hit;
        scan_reg.free      <= scan_next.free;
        scan_reg.hit_value <= scan_next.hit_value;
        scan_reg.min_stamp <= scan_next.min_stamp;
        hit_idx_reg        <= hit_idx_next;
        free_idx_reg       <= free_idx_next;
        min_idx_reg        <= min_idx_next;
        if (wr_sel) begin
            stamp_reg <= wr.stamp;
            if (wr.set_key) begin
                owner_reg  <= wr.owner;
                number_reg <= wr.number;
            end
            if (wr.set_value) begin
                value_reg <= wr.value;
            end
        end
    end

    assign scan_out     = scan_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;
    assign min_idx_out  = min_idx_reg;

endmodule

// ===== rtl/core/tagged_lru_lookup_cache_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged LRU lookup cache core
// Fully associative cache of ENTRIES slots with timestamp LRU replacement.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid / s_ready  s_op, s_owner_tag, s_object_number,
//                                         s_entry_value
//  m_       out        m_valid / m_ready  m_status, m_found_value
//
// A search token walks the row of slot cells one cell per cycle.
// The core takes one transaction at a time; s_ready is high only when idle.
// A result waits in the output register while m_ready is low; the slot write
// and the result are committed together once that register is free.
// Reset is synchronous and active low; it clears all slot valid bits and the
// use clock at once, with no clearing pass.
module tagged_lru_lookup_cache_core #(
    parameter int ENTRIES = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_owner_tag,
    input  logic [31:0] s_object_number,
    input  logic [31:0] s_entry_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_found_value
);
    import tlc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t            state_reg;
    logic              launch_reg;
    logic              op_reg;
    logic [31:0]       owner_reg;
    logic [31:0]       number_reg;
    logic [31:0]       value_reg;
    logic [31:0]       use_clock_reg;
    logic              pend_tick_reg;
    status_t           pend_status_reg;
    logic [31:0]       pend_found_reg;
    wr_cmd_t           pend_wr_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    wr_cmd_t           wr_reg;
    logic [IDX_W-1:0]  wr_idx_reg;
    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [31:0]       m_found_value_reg;

    scan_t             chain_scan     [ENTRIES+1];
    logic [IDX_W-1:0]  chain_hit_idx  [ENTRIES+1];
    logic [IDX_W-1:0]  chain_free_idx [ENTRIES+1];
    logic [IDX_W-1:0]  chain_min_idx  [ENTRIES+1];

    scan_t             end_scan;
    logic [31:0]       stamp_new;
    logic              ignored;
    logic              out_free;
    status_t           dec_status;
    logic [31:0]       dec_found;
    wr_cmd_t           dec_wr;
    logic [IDX_W-1:0]  dec_idx;

    assign chain_scan[0].active    = launch_reg;
    assign chain_scan[0].hit       = 1'b0;
    assign chain_scan[0].free      = 1'b0;
    assign chain_scan[0].hit_value = '0;
    assign chain_scan[0].min_stamp = MASK32;
    assign chain_hit_idx[0]        = '0;
    assign chain_free_idx[0]       = '0;
    assign chain_min_idx[0]        = '0;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        tlc_cell #(
            .IDX_W (IDX_W),
            .INDEX (k)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .key_owner    (owner_reg),
            .key_number   (number_reg),
            .scan_in      (chain_scan[k]),
            .hit_idx_in   (chain_hit_idx[k]),
            .free_idx_in  (chain_free_idx[k]),
            .min_idx_in   (chain_min_idx[k]),
            .scan_out     (chain_scan[k+1]),
            .hit_idx_out  (chain_hit_idx[k+1]),
            .free_idx_out (chain_free_idx[k+1]),
            .min_idx_out  (chain_min_idx[k+1]),
            .wr           (wr_reg),
            .wr_idx       (wr_idx_reg)
        );
    end

    assign end_scan  = chain_scan[ENTRIES];
    assign stamp_new = use_clock_reg + 32'd1;
    assign ignored   = (op_reg == OP_ADD) && ((owner_reg == '0) || (value_reg == '0));
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        dec_status       = STATUS_MISS;
        dec_found        = '0;
        dec_idx          = chain_hit_idx[ENTRIES];
        dec_wr.en        = 1'b0;
        dec_wr.set_key   = 1'b0;
        dec_wr.set_value = 1'b0;
        dec_wr.owner     = owner_reg;
        dec_wr.number    = number_reg;
        dec_wr.value     = value_reg;
        dec_wr.stamp     = stamp_new;
        if (op_reg == OP_LOOKUP) begin
            if (end_scan.hit) begin
                dec_status = STATUS_HIT;
                dec_found  = end_scan.hit_value;
                dec_wr.en  = 1'b1;
            end
        end else if (ignored) begin
            dec_status = STATUS_IGNORED;
        end else if (end_scan.hit) begin
            dec_status       = STATUS_UPDATED;
            dec_wr.en        = 1'b1;
            dec_wr.set_value = 1'b1;
        end else begin
            dec_wr.en        = 1'b1;
            dec_wr.set_key   = 1'b1;
            dec_wr.set_value = 1'b1;
            if (end_scan.free) begin
                dec_status = STATUS_FILLED;
                dec_idx    = chain_free_idx[ENTRIES];
            end else begin
                dec_status = STATUS_EVICTED;
                dec_idx    = chain_min_idx[ENTRIES];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            use_clock_reg <= '0;
            wr_reg.en     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            launch_reg <= 1'b0;
            wr_reg.en  <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        launch_reg <= 1'b1;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (end_scan.active) begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        wr_reg.en   <= pend_wr_reg.en;
                        m_valid_reg <= 1'b1;
                        if (pend_tick_reg) begin
                            use_clock_reg <= stamp_new;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
        if (state_reg == ST_IDLE && s_valid) begin
            op_reg     <= s_op;
            owner_reg  <= s_owner_tag;
            number_reg <= s_object_number;
            value_reg  <= s_entry_value;
        end
        if (state_reg == ST_SCAN && end_scan.active) begin
            pend_tick_reg   <= !ignored;
            pend_status_reg <= dec_status;
            pend_found_reg  <= dec_found;
            pend_wr_reg     <= dec_wr;
            pend_idx_reg    <= dec_idx;
        end
        if (state_reg == ST_COMMIT && out_free) begin
            wr_reg.set_key    <= pend_wr_reg.set_key;
            wr_reg.set_value  <= pend_wr_reg.set_value;
            wr_reg.owner      <= pend_wr_reg.owner;
            wr_reg.number     <= pend_wr_reg.number;
            wr_reg.value      <= pend_wr_reg.value;
            wr_reg.stamp      <= pend_wr_reg.stamp;
            wr_idx_reg        <= pend_idx_reg;
            m_status_reg      <= pend_status_reg;
            m_found_value_reg <= pend_found_reg;
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_value = m_found_value_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("core stayed ready after accepting a transaction");

    a_token_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        end_scan.active |-> (state_reg == ST_SCAN))
        else $error("search token left the cell row outside the scan state");

    a_write_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_reg.en |-> (m_valid_reg && (state_reg == ST_IDLE)))
        else $error("slot write issued without its result");

    a_single_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        launch_reg |=> !launch_reg)
        else $error("more than one search token launched for a transaction");
`endif

endmodule
